/* sv/hlc_pkg.sv */
// Shared types, codes and helpers of the hashed LRU cache.
package hlc_pkg;

  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned VALUE_BYTES = 8;
  localparam int unsigned HASH_W      = 11;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_MAX_LIFE = 2'd1;
  localparam logic [1:0] REG_ENTRIES  = 2'd2;
  localparam logic [1:0] REG_HASH     = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PURGE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_NO_ROOM   = 3'd2,
    STAT_DISABLED  = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_PURGE, S_MOD, S_HEAD_RD, S_HEAD_LD, S_WALK, S_CMP,
    S_HIT, S_UNL1, S_UNL2, S_MISS, S_EVICT, S_EV_RD, S_EV_LD, S_AL_RD, S_AL_WR,
    S_AL_LINK, S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RET_MISS, RET_DONE, RET_ALLOC
  } ret_e;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  klen;
    logic [63:0] val;
    logic [3:0]  vlen;
    logic [31:0] atime;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    clr_init;
    logic    clr_step;
    logic    mod_init;
    logic    mod_step;
    logic    head_ld;
    logic    cmp_ld;
    logic    hit_cnt;
    logic    to_cnt;
    logic    lk_upd;
    logic    ins_upd;
    logic    unl1;
    logic    unl2;
    logic    scan_init;
    logic    scan_step;
    logic    ev_rd;
    logic    ev_ld;
    logic    al_rd;
    logic    al_wr;
    logic    al_link;
    logic    set_st;
    status_e st;
    logic    respond;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic too_long;
    logic disabled;
    logic mod_done;
    logic cur_zero;
    logic match;
    logic timed_out;
    logic too_big;
    logic free_empty;
    logic scan_done;
    logic clr_done;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* sv/hlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/hlc_ctrl.sv */
// Sequencer of the hashed LRU cache: one operation at a time.
module hlc_ctrl import hlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic cfg_rebuild_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= RET_DONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o      = '0;
    cmd_o.st   = STAT_OK;
    in_ready_o = (state_q == S_IDLE) && !cfg_rebuild_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !cfg_rebuild_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.op == OP_PURGE) begin
          cmd_o.clr_init = 1'b1;
          state_d        = S_PURGE;
        end else if (sts_i.too_long) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_TOO_LONG;
          state_d      = S_RESP;
        end else if (sts_i.disabled && sts_i.op != OP_REMOVE) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_DISABLED;
          state_d      = S_RESP;
        end else begin
          cmd_o.mod_init = 1'b1;
          state_d        = S_MOD;
        end
      end
      S_PURGE: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_RESP;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = S_HEAD_RD;
      end
      S_HEAD_RD: state_d = S_HEAD_LD;
      S_HEAD_LD: begin
        cmd_o.head_ld = 1'b1;
        state_d       = S_WALK;
      end
      S_WALK: begin
        if (sts_i.cur_zero) begin
          state_d = S_MISS;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp_ld = 1'b1;
        if (sts_i.match) begin
          cmd_o.hit_cnt = 1'b1;
          if (sts_i.timed_out) begin
            cmd_o.to_cnt = 1'b1;
            ret_d        = RET_MISS;
            state_d      = S_UNL1;
          end else begin
            state_d = S_HIT;
          end
        end else begin
          state_d = S_WALK;
        end
      end
      S_HIT: begin
        case (sts_i.op)
          OP_LOOKUP: begin
            if (sts_i.too_big) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_NO_ROOM;
            end else begin
              cmd_o.lk_upd = 1'b1;
            end
            state_d = S_RESP;
          end
          OP_INSERT: begin
            cmd_o.ins_upd = 1'b1;
            state_d       = S_RESP;
          end
          OP_REMOVE: begin
            ret_d   = RET_DONE;
            state_d = S_UNL1;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_UNL1: begin
        cmd_o.unl1 = 1'b1;
        state_d    = S_UNL2;
      end
      S_UNL2: begin
        cmd_o.unl2 = 1'b1;
        case (ret_q)
          RET_MISS:  state_d = S_MISS;
          RET_ALLOC: state_d = S_AL_RD;
          default:   state_d = S_RESP;
        endcase
      end
      S_MISS: begin
        if (sts_i.op == OP_INSERT) begin
          if (sts_i.free_empty) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_EVICT;
          end else begin
            state_d = S_AL_RD;
          end
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_NOT_FOUND;
          state_d      = S_RESP;
        end
      end
      S_EVICT: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_EV_RD;
      end
      S_EV_RD: begin
        cmd_o.ev_rd = 1'b1;
        state_d     = S_EV_LD;
      end
      S_EV_LD: begin
        cmd_o.ev_ld = 1'b1;
        ret_d       = RET_ALLOC;
        state_d     = S_UNL1;
      end
      S_AL_RD: begin
        cmd_o.al_rd = 1'b1;
        state_d     = S_AL_WR;
      end
      S_AL_WR: begin
        cmd_o.al_wr = 1'b1;
        state_d     = S_AL_LINK;
      end
      S_AL_LINK: begin
        cmd_o.al_link = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_rebuild_i) begin
      cmd_o          = '0;
      cmd_o.st       = STAT_OK;
      cmd_o.clr_init = 1'b1;
      state_d        = S_CLEAR;
    end
  end

endmodule

/* sv/hlc_dp.sv */
// Datapath of the hashed LRU cache: entry, link and bucket memories, counters.
module hlc_dp import hlc_pkg::*; #(
  parameter int unsigned ENTRY_SLOTS  = 256,
  parameter int unsigned BUCKET_SLOTS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        enable_i,
  input  logic [15:0] max_life_i,
  input  logic [7:0]  entries_in_use_i,
  input  logic [9:0]  hash_size_i,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  input  logic [63:0] value_i,
  input  logic [3:0]  value_len_i,
  input  logic [3:0]  result_room_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [3:0]  found_len_o,
  output logic [7:0]  entry_count_o,
  output logic [31:0] lookup_count_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] timeout_count_o,
  output logic [31:0] eviction_count_o
);

  localparam int unsigned IW    = $clog2(ENTRY_SLOTS);
  localparam int unsigned BW    = $clog2(BUCKET_SLOTS);
  localparam int unsigned CLR_N = (BUCKET_SLOTS > ENTRY_SLOTS) ? BUCKET_SLOTS : ENTRY_SLOTS;
  localparam int unsigned CW    = $clog2(CLR_N);
  localparam int unsigned EMAX  = ENTRY_SLOTS - 1;
  localparam int unsigned HBW   = $clog2(HASH_W);

  // captured item
  op_e          op_q;
  logic [63:0]  key_q, val_q;
  logic [3:0]   klen_q, vlen_q, room_q;
  logic [31:0]  now_q;
  logic [HASH_W-1:0] hash_q;

  // walk and link registers
  logic [IW-1:0] cur_q, n_q, p_q, head_q, free_q;
  logic [BW-1:0] eb_q, rem_q;
  logic [HBW-1:0] bit_q;
  entry_t        ent_q;
  logic [7:0]    held_q;
  logic [31:0]   lookups_q, hits_q, timeouts_q, evictions_q;

  // eviction scan
  logic [IW-1:0] sc_q, six_q, best_q;
  logic          sc_run_q, sv_q, best_v_q;
  logic [31:0]   best_age_q;

  logic [CW-1:0] clr_q;

  status_e       res_st_q;
  logic [63:0]   fval_q;
  logic [3:0]    flen_q;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [63:0]   out_fval_q;
  logic [3:0]    out_flen_q;
  logic [7:0]    out_held_q;
  logic [31:0]   out_lk_q, out_hit_q, out_to_q, out_ev_q;

  // memory ports
  logic          bh_we, nx_we, pv_we, en_we, eb_we;
  logic [BW-1:0] bh_waddr;
  logic [IW-1:0] bh_wdata, bh_rdata;
  logic [IW-1:0] nx_waddr, nx_wdata, nx_rdata;
  logic [IW-1:0] pv_waddr, pv_wdata, pv_rdata;
  logic [IW-1:0] en_waddr, rd_addr;
  entry_t        en_wdata, en_rdata;
  logic [BW-1:0] eb_rdata;

  logic [IW-1:0] ecount;
  logic [BW:0]   bcount;
  logic [63:0]   kmask, vmask;
  logic [HASH_W-1:0] hsum;
  logic [BW:0]   mod_t;
  logic [BW-1:0] bkt;
  logic [31:0]   scan_age;
  logic [31:0]   clr_wide;

  always_comb begin
    if (entries_in_use_i == 8'd0) begin
      ecount = IW'(1);
    end else if (32'(entries_in_use_i) > EMAX) begin
      ecount = IW'(EMAX);
    end else begin
      ecount = IW'(entries_in_use_i);
    end
    if (hash_size_i == 10'd0) begin
      bcount = (BW+1)'(1);
    end else if (32'(hash_size_i) > BUCKET_SLOTS) begin
      bcount = (BW+1)'(BUCKET_SLOTS);
    end else begin
      bcount = (BW+1)'(hash_size_i);
    end
  end

  always_comb begin
    kmask = key_i & byte_mask(key_len_i);
    vmask = value_i & byte_mask(value_len_i);
    hsum  = '0;
    for (int i = 0; i < 8; i++) begin
      hsum = hsum + HASH_W'(kmask[8*i +: 8]);
    end
  end

  assign bkt      = rem_q;
  assign mod_t    = {rem_q, hash_q[bit_q]};
  assign scan_age = now_q - en_rdata.atime;
  assign clr_wide = 32'(clr_q);

  // status to the sequencer
  always_comb begin
    sts_o.op         = op_q;
    sts_o.too_long   = (32'(klen_q) > KEY_BYTES) ||
                       (op_q == OP_INSERT && 32'(vlen_q) > VALUE_BYTES);
    sts_o.disabled   = !enable_i;
    sts_o.mod_done   = (bit_q == '0);
    sts_o.cur_zero   = (cur_q == '0);
    sts_o.match      = (en_rdata.key == key_q) && (en_rdata.klen == klen_q);
    sts_o.timed_out  = (max_life_i != 16'd0) &&
                       ((now_q - en_rdata.atime) > {16'd0, max_life_i});
    sts_o.too_big    = (ent_q.vlen > room_q);
    sts_o.free_empty = (free_q == '0);
    sts_o.scan_done  = !sc_run_q && !sv_q;
    sts_o.clr_done   = (clr_q == CW'(CLR_N - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    rd_addr = cur_q;
    if (cmd_i.ev_rd) rd_addr = best_q;
    else if (cmd_i.al_rd) rd_addr = free_q;
    else if (cmd_i.scan_step) rd_addr = sc_q;

    bh_we = 1'b0; bh_waddr = bkt; bh_wdata = '0;
    nx_we = 1'b0; nx_waddr = cur_q; nx_wdata = '0;
    pv_we = 1'b0; pv_waddr = cur_q; pv_wdata = '0;
    en_we = 1'b0; en_waddr = cur_q; en_wdata = ent_q;
    eb_we = 1'b0;

    if (cmd_i.clr_step) begin
      bh_we    = (clr_wide < BUCKET_SLOTS);
      bh_waddr = clr_q[BW-1:0];
      nx_we    = (clr_wide < ENTRY_SLOTS);
      nx_waddr = clr_q[IW-1:0];
      nx_wdata = (clr_wide != 0 && clr_wide < 32'(ecount)) ? IW'(clr_wide + 1) : '0;
    end
    if (cmd_i.unl1) begin
      if (p_q == '0) begin
        bh_we    = 1'b1;
        bh_waddr = eb_q;
        bh_wdata = n_q;
      end else begin
        nx_we    = 1'b1;
        nx_waddr = p_q;
        nx_wdata = n_q;
      end
      pv_we    = (n_q != '0);
      pv_waddr = n_q;
      pv_wdata = p_q;
    end
    if (cmd_i.unl2) begin
      nx_we    = 1'b1;
      nx_waddr = cur_q;
      nx_wdata = free_q;
    end
    if (cmd_i.lk_upd) begin
      en_we          = 1'b1;
      en_wdata.atime = now_q;
    end
    if (cmd_i.ins_upd) begin
      en_we          = 1'b1;
      en_wdata.val   = val_q;
      en_wdata.vlen  = vlen_q;
      en_wdata.atime = now_q;
    end
    if (cmd_i.al_wr) begin
      bh_we    = 1'b1;
      bh_wdata = free_q;
      nx_we    = 1'b1;
      nx_waddr = free_q;
      nx_wdata = bh_rdata;
      pv_we    = 1'b1;
      pv_waddr = free_q;
      pv_wdata = '0;
      en_we    = 1'b1;
      en_waddr = free_q;
      en_wdata = '{key: key_q, klen: klen_q, val: val_q, vlen: vlen_q, atime: now_q};
      eb_we    = 1'b1;
    end
    if (cmd_i.al_link) begin
      pv_we    = (head_q != '0);
      pv_waddr = head_q;
      pv_wdata = cur_q;
    end
  end

  hlc_ram #(.WIDTH(IW), .DEPTH(BUCKET_SLOTS)) u_bucket (
    .clk_i, .we_i(bh_we), .waddr_i(bh_waddr), .wdata_i(bh_wdata),
    .raddr_i(bkt), .rdata_o(bh_rdata)
  );

  hlc_ram #(.WIDTH(IW), .DEPTH(ENTRY_SLOTS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(rd_addr), .rdata_o(nx_rdata)
  );

  hlc_ram #(.WIDTH(IW), .DEPTH(ENTRY_SLOTS)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(rd_addr), .rdata_o(pv_rdata)
  );

  hlc_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRY_SLOTS)) u_entry (
    .clk_i, .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .raddr_i(rd_addr), .rdata_o(en_rdata)
  );

  hlc_ram #(.WIDTH(BW), .DEPTH(ENTRY_SLOTS)) u_ebkt (
    .clk_i, .we_i(eb_we), .waddr_i(free_q), .wdata_i(bkt),
    .raddr_i(rd_addr), .rdata_o(eb_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(operation_i);
      key_q  <= kmask;
      klen_q <= key_len_i;
      val_q  <= vmask;
      vlen_q <= value_len_i;
      room_q <= result_room_i;
      now_q  <= now_i;
      hash_q <= hsum;
    end
    if (cmd_i.mod_init) begin
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= (mod_t >= bcount) ? BW'(mod_t - bcount) : BW'(mod_t);
    end
    if (cmd_i.cmp_ld || cmd_i.ev_ld) begin
      n_q   <= nx_rdata;
      p_q   <= pv_rdata;
      ent_q <= en_rdata;
      eb_q  <= eb_rdata;
    end
    if (cmd_i.al_wr) head_q <= bh_rdata;
    if (cmd_i.scan_step) six_q <= sc_q;
    if (cmd_i.respond) begin
      out_status_q <= res_st_q;
      out_fval_q   <= fval_q;
      out_flen_q   <= flen_q;
      out_held_q   <= held_q;
      out_lk_q     <= lookups_q;
      out_hit_q    <= hits_q;
      out_to_q     <= timeouts_q;
      out_ev_q     <= evictions_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q       <= '0;
      cur_q       <= '0;
      free_q      <= IW'(1);
      held_q      <= '0;
      lookups_q   <= '0;
      hits_q      <= '0;
      timeouts_q  <= '0;
      evictions_q <= '0;
      sc_q        <= '0;
      sc_run_q    <= 1'b0;
      sv_q        <= 1'b0;
      best_v_q    <= 1'b0;
      best_q      <= '0;
      best_age_q  <= '0;
      clr_q       <= '0;
      res_st_q    <= STAT_OK;
      fval_q      <= '0;
      flen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_init) begin
        clr_q  <= '0;
        free_q <= IW'(1);
        held_q <= '0;
      end else if (cmd_i.clr_step && clr_q != CW'(CLR_N - 1)) begin
        clr_q <= clr_q + CW'(1);
      end
      if (cmd_i.accept) begin
        res_st_q <= STAT_OK;
        fval_q   <= '0;
        flen_q   <= '0;
      end
      if (cmd_i.set_st) res_st_q <= cmd_i.st;
      if (cmd_i.mod_init) begin
        bit_q     <= HBW'(HASH_W - 1);
        lookups_q <= lookups_q + 32'd1;
      end else if (cmd_i.mod_step) begin
        bit_q <= bit_q - HBW'(1);
      end
      if (cmd_i.head_ld) cur_q <= bh_rdata;
      if (cmd_i.cmp_ld && !sts_o.match) cur_q <= nx_rdata;
      if (cmd_i.hit_cnt) hits_q <= hits_q + 32'd1;
      if (cmd_i.to_cnt) timeouts_q <= timeouts_q + 32'd1;
      if (cmd_i.lk_upd) begin
        fval_q <= ent_q.val;
        flen_q <= ent_q.vlen;
      end
      if (cmd_i.unl2) begin
        free_q <= cur_q;
        if (held_q != 8'd0) held_q <= held_q - 8'd1;
      end
      if (cmd_i.scan_init) begin
        sc_q     <= IW'(1);
        sc_run_q <= 1'b1;
        sv_q     <= 1'b0;
        best_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        sv_q <= sc_run_q;
        if (sc_run_q) begin
          sc_q <= sc_q + IW'(1);
          if (sc_q == ecount) sc_run_q <= 1'b0;
        end
        if (sv_q && (!best_v_q || scan_age > best_age_q)) begin
          best_v_q   <= 1'b1;
          best_q     <= six_q;
          best_age_q <= scan_age;
        end
      end
      if (cmd_i.ev_ld) begin
        cur_q       <= best_q;
        evictions_q <= evictions_q + 32'd1;
      end
      if (cmd_i.al_wr) begin
        cur_q  <= free_q;
        free_q <= nx_rdata;
        held_q <= held_q + 8'd1;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_value_o    = out_fval_q;
  assign found_len_o      = out_flen_q;
  assign entry_count_o    = out_held_q;
  assign lookup_count_o   = out_lk_q;
  assign hit_count_o      = out_hit_q;
  assign timeout_count_o  = out_to_q;
  assign eviction_count_o = out_ev_q;

endmodule

/* sv/hashed_lru_cache_with_aging.sv */
// Top level of the hashed LRU cache with aging: register port and core.
// One operation is worked at a time. A lookup, insert or remove runs the
// 11-step bucket modulo and then walks the chain through the registered reads
// of the link and entry memories; an insert into a full cache adds a pass
// over the active slots.
// Purge, reset and any write of entries_in_use or hash_size run a clearing
// pass over max(BUCKET_SLOTS, ENTRY_SLOTS) addresses (512 by default), during
// which no transfer is taken in. A finished result waits in an output
// register while the next item is accepted.
module hashed_lru_cache_with_aging import hlc_pkg::*; #(
  parameter int unsigned ENTRY_SLOTS  = 256,
  parameter int unsigned BUCKET_SLOTS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  input  logic [63:0] value_i,
  input  logic [3:0]  value_len_i,
  input  logic [3:0]  result_room_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [3:0]  found_len_o,
  output logic [7:0]  entry_count_o,
  output logic [31:0] lookup_count_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] timeout_count_o,
  output logic [31:0] eviction_count_o
);

  logic        enable_q;
  logic [15:0] max_life_q;
  logic [7:0]  entries_q;
  logic [9:0]  hash_size_q;
  logic        wr_en;
  logic        cfg_rebuild;
  cmd_t        cmd;
  sts_t        sts;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite;
  assign cfg_rebuild = wr_en && (paddr[3:2] == REG_ENTRIES || paddr[3:2] == REG_HASH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      max_life_q  <= '0;
      entries_q   <= 8'd255;
      hash_size_q <= 10'd318;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ENABLE:   enable_q    <= pwdata[0];
        REG_MAX_LIFE: max_life_q  <= pwdata[15:0];
        REG_ENTRIES:  entries_q   <= pwdata[7:0];
        REG_HASH:     hash_size_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:   prdata = {31'd0, enable_q};
      REG_MAX_LIFE: prdata = {16'd0, max_life_q};
      REG_ENTRIES:  prdata = {24'd0, entries_q};
      REG_HASH:     prdata = {22'd0, hash_size_q};
      default:      prdata = '0;
    endcase
  end

  hlc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .cfg_rebuild_i(cfg_rebuild),
    .sts_i(sts),
    .cmd_o(cmd),
    .in_ready_o
  );

  hlc_dp #(.ENTRY_SLOTS(ENTRY_SLOTS), .BUCKET_SLOTS(BUCKET_SLOTS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .sts_o(sts),
    .enable_i(enable_q),
    .max_life_i(max_life_q),
    .entries_in_use_i(entries_q),
    .hash_size_i(hash_size_q),
    .operation_i,
    .key_i,
    .key_len_i,
    .value_i,
    .value_len_i,
    .result_room_i,
    .now_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .found_value_o,
    .found_len_o,
    .entry_count_o,
    .lookup_count_o,
    .hit_count_o,
    .timeout_count_o,
    .eviction_count_o
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the hashed LRU cache: directed table, random phases, predictor.
module tb_top;
  import hlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_e         op;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [63:0] val;
    logic [3:0]  vlen;
    logic [3:0]  room;
    logic [31:0] now;
  } cache_req_t;

  typedef struct {
    status_e     status;
    logic [63:0] fval;
    logic [3:0]  flen;
    logic [7:0]  count;
    logic [31:0] lookups;
    logic [31:0] hits;
    logic [31:0] timeouts;
    logic [31:0] evictions;
  } cache_rsp_t;

  typedef struct {
    cache_req_t  req;
    bit          typed;
    status_e     status;
  } table_row_t;

  typedef struct {
    logic        en;
    logic [15:0] life;
    logic [7:0]  entries;
    logic [9:0]  hashes;
    int          items;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [63:0] key_i = '0;
  logic [3:0]  key_len_i = '0;
  logic [63:0] value_i = '0;
  logic [3:0]  value_len_i = '0;
  logic [3:0]  result_room_i = '0;
  logic [31:0] now_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] found_value_o;
  logic [3:0]  found_len_o;
  logic [7:0]  entry_count_o;
  logic [31:0] lookup_count_o;
  logic [31:0] hit_count_o;
  logic [31:0] timeout_count_o;
  logic [31:0] eviction_count_o;

  hashed_lru_cache_with_aging i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow cache
  logic        sh_en;
  logic [15:0] sh_life;
  logic [7:0]  sh_entries;
  logic [9:0]  sh_hashes;
  logic [63:0] sh_key [256];
  logic [3:0]  sh_klen [256];
  logic [63:0] sh_val [256];
  logic [3:0]  sh_vlen [256];
  int unsigned sh_hash [256];
  logic [31:0] sh_atime [256];
  bit          sh_valid [256];
  int unsigned sh_next [256];
  int unsigned sh_prev [256];
  int unsigned sh_bucket [512];
  int unsigned sh_free;
  int unsigned sh_held;
  logic [31:0] n_lookups, n_hits, n_timeouts, n_evictions;

  cache_rsp_t  rsp_q [$];
  int          fails = 0;
  int          burst_left = 0;
  logic [31:0] t_now = '0;
  logic [63:0] pool_key [16];
  logic [3:0]  pool_len [16];

  function automatic logic [63:0] bmask(input int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic int unsigned active_slots();
    return (sh_entries == 0) ? 1 : int'(sh_entries);
  endfunction

  function automatic int unsigned active_buckets();
    return (sh_hashes == 0) ? 1 : ((sh_hashes > 512) ? 512 : int'(sh_hashes));
  endfunction

  function automatic void clear_cache();
    int unsigned e;
    e = active_slots();
    for (int i = 0; i < 256; i++) begin
      sh_valid[i] = 0;
      sh_next[i] = 0;
      sh_prev[i] = 0;
    end
    for (int i = 0; i < 512; i++) sh_bucket[i] = 0;
    for (int unsigned i = 1; i <= e; i++) sh_next[i] = (i < e) ? i + 1 : 0;
    sh_free = 1;
    sh_held = 0;
  endfunction

  function automatic void drop_entry(input int unsigned ix);
    int unsigned b, p, n;
    b = sh_hash[ix] % active_buckets();
    p = sh_prev[ix];
    n = sh_next[ix];
    if (p == 0) sh_bucket[b] = n;
    else sh_next[p] = n;
    if (n != 0) sh_prev[n] = p;
    sh_valid[ix] = 0;
    sh_prev[ix] = 0;
    sh_next[ix] = sh_free;
    sh_free = ix;
    if (sh_held > 0) sh_held--;
  endfunction

  function automatic int unsigned find_key(input logic [63:0] key, input logic [3:0] klen,
                                           input int unsigned hash, input logic [31:0] now);
    int unsigned ix, guard;
    logic [31:0] age;
    ix = sh_bucket[hash % active_buckets()];
    guard = 0;
    n_lookups++;
    while (ix != 0 && guard < 256) begin
      if (sh_valid[ix] && sh_hash[ix] == hash && sh_klen[ix] == klen && sh_key[ix] == key) begin
        n_hits++;
        age = now - sh_atime[ix];
        if (sh_life != 0 && age > {16'd0, sh_life}) begin
          n_timeouts++;
          drop_entry(ix);
          return 0;
        end
        return ix;
      end
      ix = sh_next[ix];
      guard++;
    end
    return 0;
  endfunction

  function automatic void evict_stalest(input logic [31:0] now);
    int unsigned best;
    logic [31:0] best_age, age;
    best = 0;
    best_age = '0;
    for (int unsigned i = 1; i <= active_slots(); i++) begin
      if (sh_valid[i]) begin
        age = now - sh_atime[i];
        if (best == 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    if (best != 0) begin
      drop_entry(best);
      n_evictions++;
    end
  endfunction

  function automatic cache_rsp_t predict_cache(input cache_req_t r);
    cache_rsp_t  o;
    logic [63:0] key;
    int unsigned hash, ix, b;
    o.status = STAT_OK;
    o.fval = '0;
    o.flen = '0;
    if (r.op == OP_PURGE) begin
      clear_cache();
    end else if (r.klen > 8 || (r.op == OP_INSERT && r.vlen > 8)) begin
      o.status = STAT_TOO_LONG;
    end else if (r.op != OP_REMOVE && !sh_en) begin
      o.status = STAT_DISABLED;
    end else begin
      key = r.key & bmask(r.klen);
      hash = 0;
      for (int i = 0; i < r.klen; i++) hash += key[8*i +: 8];
      ix = find_key(key, r.klen, hash, r.now);
      case (r.op)
        OP_INSERT: begin
          if (ix == 0) begin
            if (sh_free == 0) evict_stalest(r.now);
            ix = sh_free;
            if (ix != 0) begin
              b = hash % active_buckets();
              sh_free = sh_next[ix];
              sh_held++;
              sh_prev[ix] = 0;
              sh_next[ix] = sh_bucket[b];
              if (sh_bucket[b] != 0) sh_prev[sh_bucket[b]] = ix;
              sh_bucket[b] = ix;
              sh_valid[ix] = 1;
              sh_hash[ix] = hash;
              sh_key[ix] = key;
              sh_klen[ix] = r.klen;
            end
          end
          if (ix != 0) begin
            sh_val[ix] = r.val & bmask(r.vlen);
            sh_vlen[ix] = r.vlen;
            sh_atime[ix] = r.now;
          end
        end
        OP_LOOKUP: begin
          if (ix == 0) o.status = STAT_NOT_FOUND;
          else if (sh_vlen[ix] > r.room) o.status = STAT_NO_ROOM;
          else begin
            sh_atime[ix] = r.now;
            o.fval = sh_val[ix];
            o.flen = sh_vlen[ix];
          end
        end
        default: begin
          if (ix == 0) o.status = STAT_NOT_FOUND;
          else drop_entry(ix);
        end
      endcase
    end
    o.count = sh_held[7:0];
    o.lookups = n_lookups;
    o.hits = n_hits;
    o.timeouts = n_timeouts;
    o.evictions = n_evictions;
    return o;
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:   sh_en = data[0];
      REG_MAX_LIFE: sh_life = data[15:0];
      REG_ENTRIES:  begin sh_entries = data[7:0]; clear_cache(); end
      default:      begin sh_hashes = data[9:0]; clear_cache(); end
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send(input cache_req_t r, input bit typed, input status_e st);
    int gap;
    cache_rsp_t e;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= r.op;
    key_i <= r.key;
    key_len_i <= r.klen;
    value_i <= r.val;
    value_len_i <= r.vlen;
    result_room_i <= r.room;
    now_i <= r.now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = predict_cache(r);
    if (typed) e.status = st;
    rsp_q.push_back(e);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic cache_req_t random_req();
    cache_req_t r;
    int unsigned sel, j;
    sel = $urandom_range(0, 99);
    r.op = (sel < 45) ? OP_INSERT : (sel < 80) ? OP_LOOKUP : (sel < 99) ? OP_REMOVE : OP_PURGE;
    j = $urandom_range(0, 15);
    r.klen = pool_len[j];
    r.key = (pool_key[j] & bmask(r.klen)) | ({$urandom, $urandom} & ~bmask(r.klen));
    if ($urandom_range(0, 24) == 0) r.klen = 4'($urandom_range(9, 15));
    r.val = {$urandom, $urandom};
    r.vlen = 4'(($urandom_range(0, 24) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
    r.room = 4'(($urandom_range(0, 6) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
    if ($urandom_range(0, 49) == 0) t_now = $urandom;
    else t_now += $urandom_range(0, 6);
    r.now = t_now;
    return r;
  endfunction

  function automatic cache_req_t mk(input op_e op, input logic [63:0] key, input logic [3:0] klen,
                                    input logic [63:0] val, input logic [3:0] vlen,
                                    input logic [3:0] room, input logic [31:0] now);
    cache_req_t r;
    r.op = op; r.key = key; r.klen = klen; r.val = val;
    r.vlen = vlen; r.room = room; r.now = now;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cache_rsp_t e;
    if (out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        $error("unexpected result transfer");
        fails++;
      end else begin
        e = rsp_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fails++;
        end
        if (found_value_o !== e.fval) begin
          $error("found_value exp %h got %h", e.fval, found_value_o); fails++;
        end
        if (found_len_o !== e.flen) begin
          $error("found_len exp %0d got %0d", e.flen, found_len_o); fails++;
        end
        if (entry_count_o !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, entry_count_o); fails++;
        end
        if (lookup_count_o !== e.lookups) begin
          $error("lookup_count exp %0d got %0d", e.lookups, lookup_count_o); fails++;
        end
        if (hit_count_o !== e.hits) begin
          $error("hit_count exp %0d got %0d", e.hits, hit_count_o); fails++;
        end
        if (timeout_count_o !== e.timeouts) begin
          $error("timeout_count exp %0d got %0d", e.timeouts, timeout_count_o); fails++;
        end
        if (eviction_count_o !== e.evictions) begin
          $error("eviction_count exp %0d got %0d", e.evictions, eviction_count_o); fails++;
        end
      end
    end
  end

  int stall_left = 0;
  int stall_mode = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    table_row_t dir_rows [$];
    phase_t     phases [$];
    sh_en = 1'b1;
    sh_life = '0;
    sh_entries = 8'd255;
    sh_hashes = 10'd318;
    n_lookups = '0;
    n_hits = '0;
    n_timeouts = '0;
    n_evictions = '0;
    clear_cache();

    dir_rows = '{
      '{mk(OP_LOOKUP, '0, 4'd0, '0, 4'd0, 4'd8, 32'd0), 1, STAT_NOT_FOUND},
      '{mk(OP_INSERT, '0, 4'd0, '1, 4'd8, 4'd0, 32'd1), 1, STAT_OK},
      '{mk(OP_LOOKUP, '1, 4'd0, '0, 4'd0, 4'd8, 32'd2), 0, STAT_OK},
      '{mk(OP_LOOKUP, '0, 4'd0, '0, 4'd0, 4'd7, 32'd3), 1, STAT_NO_ROOM},
      '{mk(OP_INSERT, '1, 4'd8, '0, 4'd0, 4'd0, 32'd4), 1, STAT_OK},
      '{mk(OP_LOOKUP, '1, 4'd8, '0, 4'd0, 4'd0, 32'd5), 0, STAT_OK},
      '{mk(OP_INSERT, '1, 4'd9, '0, 4'd0, 4'd0, 32'd6), 1, STAT_TOO_LONG},
      '{mk(OP_INSERT, '1, 4'd8, '1, 4'd15, 4'd0, 32'd6), 1, STAT_TOO_LONG},
      '{mk(OP_LOOKUP, '1, 4'd15, '0, 4'd0, 4'd8, 32'd6), 1, STAT_TOO_LONG},
      '{mk(OP_REMOVE, '1, 4'd9, '0, 4'd0, 4'd8, 32'd6), 1, STAT_TOO_LONG},
      '{mk(OP_PURGE, '1, 4'd15, '1, 4'd15, 4'd15, '1), 1, STAT_OK},
      '{mk(OP_INSERT, 64'hAA0102, 4'd2, 64'h1234_5678, 4'd4, 4'd0, 32'd10), 0, STAT_OK},
      '{mk(OP_INSERT, 64'h0102, 4'd2, 64'hFEED_BEEF_CAFE, 4'd6, 4'd0, 32'd11), 0, STAT_OK},
      '{mk(OP_INSERT, 64'h0201, 4'd2, 64'h55, 4'd1, 4'd0, 32'd12), 0, STAT_OK},
      '{mk(OP_LOOKUP, 64'h0102, 4'd2, '0, 4'd0, 4'd8, 32'd13), 0, STAT_OK},
      '{mk(OP_REMOVE, 64'h0201, 4'd2, '0, 4'd0, 4'd0, 32'd14), 0, STAT_OK},
      '{mk(OP_REMOVE, 64'h0201, 4'd2, '0, 4'd0, 4'd0, 32'd15), 1, STAT_NOT_FOUND},
      '{mk(OP_LOOKUP, 64'h0102, 4'd2, '0, 4'd0, 4'd15, '1), 0, STAT_OK}
    };

    phases = '{
      '{1'b1, 16'd0,     8'd4,   10'd3,    300},
      '{1'b1, 16'd20,    8'd16,  10'd512,  300},
      '{1'b1, 16'd65535, 8'd255, 10'd1,    150},
      '{1'b0, 16'd5,     8'd0,   10'd0,    150},
      '{1'b1, 16'd5,     8'd0,   10'd0,    250},
      '{1'b1, 16'd3,     8'd8,   10'd1023, 300},
      '{1'b1, 16'd0,     8'd200, 10'd7,    250},
      '{1'b1, 16'd65535, 8'd2,   10'd2,    230}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status);
    drain();

    foreach (phases[p]) begin
      reg_write(REG_ENABLE, {31'd0, phases[p].en});
      reg_write(REG_MAX_LIFE, {16'd0, phases[p].life});
      reg_write(REG_ENTRIES, {24'd0, phases[p].entries});
      reg_write(REG_HASH, {22'd0, phases[p].hashes});
      for (int j = 0; j < 16; j++) begin
        pool_key[j] = {$urandom, $urandom};
        pool_len[j] = 4'($urandom_range(0, 8));
      end
      for (int n = 0; n < phases[p].items; n++) begin
        send(random_req(), 0, STAT_OK);
        if (n % 97 == 96) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/hlc_pkg.sv
sv/hlc_ram.sv
sv/hlc_ctrl.sv
sv/hlc_dp.sv
sv/hashed_lru_cache_with_aging.sv
sim/tb_top.sv
